// ----- rtl/mcbp_pkg.sv -----
package mcbp_pkg;

  localparam int DEF_NUM_CHANNELS = 8;
  localparam int DEF_BUFFER_DEPTH = 4096;

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_WRITE    = 3'd1;
  localparam logic [2:0] OP_READ     = 3'd2;
  localparam logic [2:0] OP_CLOSE_RD = 3'd3;
  localparam logic [2:0] OP_CLOSE_WR = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_EOF     = 3'd4;
  localparam logic [2:0] ST_BROKEN  = 3'd5;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] channel;
    logic [7:0] data_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data_out;
    logic [2:0] new_channel;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ----- rtl/mcbp_store.sv -----
module mcbp_store #(
  parameter int DEPTH  = mcbp_pkg::DEF_NUM_CHANNELS * mcbp_pkg::DEF_BUFFER_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  mcbp_pkg::mem_ctl_t  ctl,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [7:0]          wdata,
  output logic [7:0]          rdata
);
  import mcbp_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mcbp_ctrl.sv -----
module mcbp_ctrl #(
  parameter int NUM_CHANNELS = mcbp_pkg::DEF_NUM_CHANNELS,
  parameter int BUFFER_DEPTH = mcbp_pkg::DEF_BUFFER_DEPTH,
  parameter int ADDR_W       = $clog2(NUM_CHANNELS * BUFFER_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_vld,
  input  mcbp_pkg::in_item_t   item,
  output mcbp_pkg::mem_ctl_t   mem_ctl,
  output logic [ADDR_W-1:0]    mem_addr,
  output logic [7:0]           mem_wdata,
  output logic                 res_vld,
  output mcbp_pkg::out_item_t  res,
  output logic                 res_rd_ok
);
  import mcbp_pkg::*;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W  = $clog2(BUFFER_DEPTH);
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

  logic [NUM_CHANNELS-1:0] used_r, used_nxt;
  logic [NUM_CHANNELS-1:0] rd_open_r, rd_open_nxt;
  logic [NUM_CHANNELS-1:0] wr_open_r, wr_open_nxt;
  logic [PTR_W-1:0]        head_r [NUM_CHANNELS];
  logic [PTR_W-1:0]        head_nxt [NUM_CHANNELS];
  logic [PTR_W-1:0]        tail_r [NUM_CHANNELS];
  logic [PTR_W-1:0]        tail_nxt [NUM_CHANNELS];
  logic [FILL_W-1:0]       fill_r [NUM_CHANNELS];
  logic [FILL_W-1:0]       fill_nxt [NUM_CHANNELS];

  logic                    res_vld_r;
  out_item_t               res_r, res_nxt;
  logic                    rd_ok_r, rd_ok_nxt;

  logic                    free_found;
  logic [CH_W-1:0]         free_idx;
  logic [CH_W-1:0]         ch_idx;
  logic                    ch_valid;
  logic [PTR_W-1:0]        ptr_sel;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    // scan from the top so the lowest free pipe wins
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  assign ch_idx   = CH_W'(item.channel);
  assign ch_valid = int'(item.channel) < NUM_CHANNELS;

  always_comb begin
    used_nxt    = used_r;
    rd_open_nxt = rd_open_r;
    wr_open_nxt = wr_open_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    res_nxt     = '0;
    res_nxt.status   = ST_INVALID;
    res_nxt.last_out = item.last_byte;
    rd_ok_nxt   = 1'b0;
    mem_ctl     = '0;
    ptr_sel     = tail_r[ch_idx];

    if (item_vld) begin
      unique case (item.opcode) inside
        OP_CREATE: begin
          if (free_found) begin
            head_nxt[free_idx]    = '0;
            tail_nxt[free_idx]    = '0;
            fill_nxt[free_idx]    = '0;
            rd_open_nxt[free_idx] = 1'b1;
            wr_open_nxt[free_idx] = 1'b1;
            used_nxt[free_idx]    = 1'b1;
            res_nxt.status        = ST_OK;
            res_nxt.new_channel   = 3'(free_idx);
          end
        end
        OP_WRITE: begin
          if (ch_valid) begin
            if (!used_r[ch_idx] || !wr_open_r[ch_idx]) begin
              res_nxt.status = ST_INVALID;
            end else if (!rd_open_r[ch_idx]) begin
              res_nxt.status = ST_BROKEN;
            end else if (fill_r[ch_idx] == FILL_W'(BUFFER_DEPTH)) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_ctl.wr_en    = 1'b1;
              ptr_sel          = tail_r[ch_idx];
              tail_nxt[ch_idx] = (tail_r[ch_idx] == PTR_W'(BUFFER_DEPTH - 1)) ? '0
                                 : tail_r[ch_idx] + PTR_W'(1);
              fill_nxt[ch_idx] = fill_r[ch_idx] + FILL_W'(1);
              res_nxt.status   = ST_OK;
            end
          end
        end
        OP_READ: begin
          if (ch_valid) begin
            if (!used_r[ch_idx] || !rd_open_r[ch_idx]) begin
              res_nxt.status = ST_INVALID;
            end else if (fill_r[ch_idx] == '0) begin
              res_nxt.status = wr_open_r[ch_idx] ? ST_EMPTY : ST_EOF;
            end else begin
              mem_ctl.rd_en    = 1'b1;
              rd_ok_nxt        = 1'b1;
              ptr_sel          = head_r[ch_idx];
              head_nxt[ch_idx] = (head_r[ch_idx] == PTR_W'(BUFFER_DEPTH - 1)) ? '0
                                 : head_r[ch_idx] + PTR_W'(1);
              fill_nxt[ch_idx] = fill_r[ch_idx] - FILL_W'(1);
              res_nxt.status   = ST_OK;
            end
          end
        end
        OP_CLOSE_RD, OP_CLOSE_WR: begin
          if (ch_valid && used_r[ch_idx]) begin
            if (item.opcode == OP_CLOSE_RD) begin
              rd_open_nxt[ch_idx] = 1'b0;
            end else begin
              wr_open_nxt[ch_idx] = 1'b0;
            end
            // free the pipe once both ends are shut
            if (!rd_open_nxt[ch_idx] && !wr_open_nxt[ch_idx]) begin
              used_nxt[ch_idx] = 1'b0;
            end
            res_nxt.status = ST_OK;
          end
        end
        default: begin
          res_nxt.status = ST_INVALID;
        end
      endcase
    end
  end

  assign mem_addr  = ADDR_W'(ch_idx) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(ptr_sel);
  assign mem_wdata = item.data_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_open_r <= '0;
      wr_open_r <= '0;
      res_vld_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      used_r    <= used_nxt;
      rd_open_r <= rd_open_nxt;
      wr_open_r <= wr_open_nxt;
      res_vld_r <= item_vld;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  assign res_vld   = res_vld_r;
  assign res       = res_r;
  assign res_rd_ok = rd_ok_r;

endmodule

// ----- rtl/multi_channel_byte_pipe.sv -----
// Table of byte pipes, each a ring buffer with its own read and write ends.
// A transaction is taken on every cycle in which start is high; busy never
// rises, so one transaction per clock is sustained. Each transaction gives
// exactly one result: out_valid is high for one cycle with it. The transaction
// is captured in the input register, then the table update and the byte
// store access are registered into the result register and the store read
// register, which drive out_valid and out_data.
// Results arrive in order and cannot be stalled: the receiver must take
// every one. No clearing pass after reset; pipes become usable at once. A
// read of a byte never written is undefined.
module multi_channel_byte_pipe #(
  parameter int NUM_CHANNELS = mcbp_pkg::DEF_NUM_CHANNELS,
  parameter int BUFFER_DEPTH = mcbp_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mcbp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output mcbp_pkg::out_item_t  out_data
);
  import mcbp_pkg::*;

  localparam int STORE_DEPTH = NUM_CHANNELS * BUFFER_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  logic              in_vld_r;
  in_item_t          in_r;
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic              res_vld;
  out_item_t         res;
  logic              res_rd_ok;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  mcbp_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_vld_r),
    .item      (in_r),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .res_vld   (res_vld),
    .res       (res),
    .res_rd_ok (res_rd_ok)
  );

  mcbp_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_data          = res;
    // drop the stale store output unless this transaction read a byte
    out_data.data_out = res_rd_ok ? mem_rdata : 8'd0;
  end

  assign out_valid = res_vld;

endmodule
